@@ design/i4dq_pkg.sv @@
`timescale 1ns / 1ps

package i4dq_pkg;

	localparam int ACC_W   = 24;
	localparam int SCALE_W = 16;
	localparam int PROD1_W = ACC_W + SCALE_W;
	localparam int RES_W   = PROD1_W + SCALE_W;

	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 80;

	// entries in the queue between front and back; a power of two
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W + 1)'(8388607);
	localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W + 1)'(8388608);

	// one finished dot product waiting for dequantization
	typedef struct packed {
		logic signed [ACC_W-1:0]   acc;
		logic signed [SCALE_W-1:0] wscale;
		logic signed [SCALE_W-1:0] ascale;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// code minus 8 equals the nibble with its top bit flipped, read as signed
	function automatic logic signed [3:0] nib_weight(input logic [3:0] code);
		return {~code[3], code[2:0]};
	endfunction

endpackage

@@ design/i4dq_front.sv @@
`timescale 1ns / 1ps

module i4dq_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [i4dq_pkg::S_DATA_W-1:0]   s_tdata,  // weight_byte, act_first, act_second,
	                                                  // weight_scale, act_scale
	input  logic                            s_tuser,  // second_present
	input  logic                            s_tlast,
	input  i4dq_pkg::q_stat_t               qstat,
	output logic                            push,
	output i4dq_pkg::q_entry_t              push_entry
);

	logic signed [i4dq_pkg::ACC_W-1:0] acc_q;
	logic signed [3:0]                 w0, w1;
	logic signed [7:0]                 a0, a1;
	logic signed [11:0]                p0, p1;
	logic signed [12:0]                contrib;
	logic signed [i4dq_pkg::ACC_W:0]   sum;
	logic signed [i4dq_pkg::ACC_W-1:0] acc_next;
	logic                              xfer;

	assign s_tready = !qstat.full;
	assign xfer     = s_tvalid && s_tready;

	always_comb begin
		w0 = i4dq_pkg::nib_weight(s_tdata[3:0]);
		w1 = i4dq_pkg::nib_weight(s_tdata[7:4]);
		a0 = $signed(s_tdata[15:8]);
		a1 = $signed(s_tdata[23:16]);
		p0 = w0 * a0;
		p1 = s_tuser ? w1 * a1 : 12'sd0;
		contrib = 13'(p0) + 13'(p1);
		sum = (i4dq_pkg::ACC_W + 1)'(acc_q) + (i4dq_pkg::ACC_W + 1)'(contrib);
		if (sum > i4dq_pkg::ACC_MAX) begin
			acc_next = i4dq_pkg::ACC_MAX[i4dq_pkg::ACC_W-1:0];
		end else if (sum < i4dq_pkg::ACC_MIN) begin
			acc_next = i4dq_pkg::ACC_MIN[i4dq_pkg::ACC_W-1:0];
		end else begin
			acc_next = sum[i4dq_pkg::ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (xfer) begin
			acc_q <= s_tlast ? '0 : acc_next;
		end
	end

	assign push              = xfer && s_tlast;
	assign push_entry.acc    = acc_next;
	assign push_entry.wscale = $signed(s_tdata[39:24]);
	assign push_entry.ascale = $signed(s_tdata[55:40]);

endmodule

@@ design/i4dq_queue.sv @@
`timescale 1ns / 1ps

module i4dq_queue #(
	parameter int DEPTH = i4dq_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i4dq_pkg::q_entry_t push_entry,
	input  logic               pop,
	output i4dq_pkg::q_entry_t pop_entry,
	output i4dq_pkg::q_stat_t  qstat
);

	localparam int PW = $clog2(DEPTH);

	i4dq_pkg::q_entry_t entries_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [PW:0]        count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_entry   = entries_q[rd_ptr_q];
	assign qstat.full  = (count_q == (PW + 1)'(DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

@@ design/i4dq_back.sv @@
`timescale 1ns / 1ps

module i4dq_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i4dq_pkg::q_stat_t             qstat,
	input  i4dq_pkg::q_entry_t            pop_entry,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [i4dq_pkg::M_DATA_W-1:0] m_tdata   // scaled_result, raw_dot
);

	logic                                valid_s1, valid_s2;
	logic signed [i4dq_pkg::PROD1_W-1:0] prod_s1;
	logic signed [i4dq_pkg::SCALE_W-1:0] ascale_s1;
	logic signed [i4dq_pkg::ACC_W-1:0]   acc_s1, acc_s2;
	logic signed [i4dq_pkg::RES_W-1:0]   scaled_s2;
	logic                                adv_s2, adv_s1;

	assign adv_s2 = !valid_s2 || m_tready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = !qstat.empty && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// acc * weight scale, then * activation scale; exact, no rounding
	always_ff @(posedge clk) begin
		if (adv_s1 && pop) begin
			prod_s1   <= pop_entry.acc * pop_entry.wscale;
			ascale_s1 <= pop_entry.ascale;
			acc_s1    <= pop_entry.acc;
		end
		if (adv_s2 && valid_s1) begin
			scaled_s2 <= prod_s1 * ascale_s1;
			acc_s2    <= acc_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {acc_s2, scaled_s2};

endmodule

@@ design/int4_int8_dot_dequant.sv @@
`timescale 1ns / 1ps

// channel  dir  tdata (low bit up)                                         tuser           tlast
// s_*      in   weight_byte, act_first, act_second, weight_scale, act_scale  second_present  last
// m_*      out  scaled_result[55:0], raw_dot[79:56]                        -               -
//
// One input transfer per cycle while the result queue has room; the
// multiply-add and saturation into the 24-bit accumulator finish in that cycle.
// A transfer with tlast queues the dot product; the back end pops it and scales it
// through two registered multiplies, s1 and s2, before m_tvalid rises.
// Reset clears the accumulator, the queue and the output stage.
// Output stalls fill the queue; s_tready drops only when it is full.
module int4_int8_dot_dequant #(
	parameter int QDEPTH = i4dq_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [i4dq_pkg::S_DATA_W-1:0] s_tdata,  // weight_byte, act_first, act_second,
	                                                // weight_scale, act_scale
	input  logic                          s_tuser,  // second_present
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [i4dq_pkg::M_DATA_W-1:0] m_tdata   // scaled_result, raw_dot
);

	i4dq_pkg::q_stat_t  qstat;
	i4dq_pkg::q_entry_t push_entry, pop_entry;
	logic               push, pop;

	i4dq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	i4dq_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	i4dq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_entry (pop_entry),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_zero_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[79:56] == '0) |-> m_tdata[55:0] == '0)
		else $error("zero dot product with nonzero scaled result");

endmodule
